### rtl/ssoc_pkg.sv
// ssoc_pkg: shared types and constants of the state-space observer controller
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package ssoc_pkg;
  localparam int QW = 32;
  localparam int PW = 64;
  localparam logic [2:0] TAB_A  = 3'd0;
  localparam logic [2:0] TAB_B  = 3'd1;
  localparam logic [2:0] TAB_C  = 3'd2;
  localparam logic [2:0] TAB_K  = 3'd3;
  localparam logic [2:0] TAB_L  = 3'd4;
  localparam logic [2:0] TAB_LO = 3'd5;
  localparam logic [2:0] TAB_HI = 3'd6;

  // one dot-product term handed to a lane
  typedef struct packed {
    logic            clr;
    logic            en;
    logic [QW-1:0]   a;
    logic [QW-1:0]   b;
  } lane_cmd_t;

  function automatic logic [QW-1:0] sat32(input logic signed [PW+7:0] x);
    logic signed [PW+7:0] mx;
    logic signed [PW+7:0] mn;
    begin
      mx = 72'sh7FFFFFFF;
      mn = -72'sh80000000;
      if (x > mx) sat32 = 32'h7FFFFFFF;
      else if (x < mn) sat32 = 32'h80000000;
      else sat32 = x[QW-1:0];
    end
  endfunction

  function automatic logic [QW-1:0] sadd(input logic [QW-1:0] a, input logic [QW-1:0] b,
                                        input logic neg);
    logic signed [PW+7:0] s;
    begin
      if (neg) s = 72'(signed'(a)) - 72'(signed'(b));
      else s = 72'(signed'(a)) + 72'(signed'(b));
      sadd = sat32(s);
    end
  endfunction
endpackage
`default_nettype wire

### rtl/state_space_observer_controller.sv
// state_space_observer_controller: top level, coefficient stores and step sequencer
// depends on ssoc_pkg, ssoc_lane, ssoc_merge
`timescale 1ns / 1ps
`default_nettype none
// Discrete state-space regulator with a Luenberger observer in signed Q16.16.
// Load items (tuser mode 0) write one coefficient or drive limit and give no
// result; step items (mode 1) compute U = K(R - xhat), clamp it, return one
// result and update xhat = (A - LC)xhat + LY + BU. Two multiply lanes split
// every dot product by even and odd term index; a merge stage sums the lanes,
// shifts and saturates. A load leaves the sequencer idle, so loads can follow back to
// back. A step runs a sequencer over rows: each dot product issues its terms two
// at a time, drains the product, accumulator and merge registers and is then
// stored. A full 4-state, 2-output step walks 2 + 16 + 12 dot products between
// the difference and write-back states; no new item is taken while a step
// runs, so step throughput is set by the two shared multipliers. The result
// waits in an output register; items are still taken while it waits, and a
// following step holds in write-back until the waiting result has been taken.
module state_space_observer_controller
  import ssoc_pkg::*;
#(
  parameter int MAX_STATES  = 4,
  parameter int MAX_OUTPUTS = 2
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic         cfg_index,
  input  wire logic [2:0]   cfg_data,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // mode, table_req
  input  wire logic [3:0]   s_tuser,
  // row, col, coef_value, ref0..ref3, meas0, meas1, pad
  input  wire logic [231:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // drive0, drive1, drive0_raw, drive1_raw, drive0_limited, drive1_limited, pad
  output logic [135:0]      m_tdata
);
  localparam int NS = MAX_STATES;
  localparam int NO = MAX_OUTPUTS;
  localparam int LANES = 2;
  localparam int IW = (NS > NO ? NS : NO) > 1 ? $clog2(NS > NO ? NS : NO) : 1;
  localparam int SW = NS > 1 ? $clog2(NS) : 1;
  localparam int OW = NO > 1 ? $clog2(NO) : 1;
  localparam logic [3:0] ST_IDLE = 4'd0, ST_R1 = 4'd1, ST_U = 4'd2, ST_LC = 4'd3,
    ST_AX = 4'd4, ST_LY = 4'd5, ST_BU = 4'd6, ST_WAIT = 4'd7, ST_STORE = 4'd8,
    ST_DONE = 4'd9;

  logic [2:0] num_states;
  logic [1:0] num_outputs;
  logic [QW-1:0] a_store [NS][NS];
  logic [QW-1:0] b_store [NS][NO];
  logic [QW-1:0] c_store [NO][NS];
  logic [QW-1:0] k_store [NO][NS];
  logic [QW-1:0] l_store [NS][NO];
  logic [QW-1:0] low_limits [NO];
  logic [QW-1:0] high_limits [NO];
  logic [QW-1:0] estimate [NS];
  logic [QW-1:0] nx [NS];
  logic [QW-1:0] r1 [NS];
  logic [QW-1:0] rv [4];
  logic [QW-1:0] yv [2];
  logic [QW-1:0] u [NO];
  logic [QW-1:0] uraw [NO];
  logic          lim [NO];
  logic [QW-1:0] alc [NS][NS];
  logic [QW-1:0] sx, sy;
  logic [135:0]  res_word;

  logic [3:0] state;
  logic [3:0] ph;        // phase that issued the running dot product
  logic [IW-1:0] ri, ci; // row and column of the current dot product
  logic [IW:0] ti;       // term index (even lane 0, odd lane 1)
  logic [2:0] drain;
  logic [IW:0] ns, no;

  lane_cmd_t cmd [LANES];
  logic signed [LANES*(PW+8)-1:0] sums;
  logic [QW-1:0] mres;

  logic       mode;
  logic [2:0] tab;
  logic [1:0] lrow, lcol;
  logic [QW-1:0] cval;
  assign mode = s_tuser[0];
  assign tab  = s_tuser[3:1];
  assign lrow = s_tdata[1:0];
  assign lcol = s_tdata[3:2];
  assign cval = s_tdata[35:4];

  always_comb begin
    ns = (num_states == 3'd0) ? (IW+1)'(1) :
         (32'(num_states) > NS) ? (IW+1)'(NS) : (IW+1)'(num_states);
    no = (num_outputs == 2'd0) ? (IW+1)'(1) :
         (32'(num_outputs) > NO) ? (IW+1)'(NO) : (IW+1)'(num_outputs);
  end

  assign s_tready = (state == ST_IDLE);

  genvar g;
  generate
    for (g = 0; g < LANES; g++) begin : g_lane
      ssoc_lane u_lane (.clk(clk), .cmd(cmd[g]), .acc(sums[g*(PW+8) +: (PW+8)]));
    end
  endgenerate
  ssoc_merge #(.LANES(LANES)) u_merge (.clk(clk), .sums(sums), .result(mres));

  // length of current dot product
  logic [IW:0] tlen;
  always_comb begin
    case (state)
      ST_U, ST_AX: tlen = ns;
      default:     tlen = no;
    endcase
  end

  // operand selection per lane
  always_comb begin
    logic [IW:0] t;
    logic        val;
    for (int l = 0; l < LANES; l++) begin
      t = ti + (IW+1)'(l);
      val = (state == ST_U || state == ST_LC || state == ST_AX ||
             state == ST_LY || state == ST_BU) && (t < tlen);
      cmd[l].clr = (state == ST_R1) || (state == ST_STORE);
      cmd[l].en  = val;
      cmd[l].a   = '0;
      cmd[l].b   = '0;
      if (val) begin
        case (state)
          ST_U:  begin
            cmd[l].a = k_store[OW'(ri)][SW'(t)];
            cmd[l].b = r1[SW'(t)];
          end
          ST_LC: begin
            cmd[l].a = l_store[SW'(ri)][OW'(t)];
            cmd[l].b = c_store[OW'(t)][SW'(ci)];
          end
          ST_AX: begin
            cmd[l].a = alc[SW'(ri)][SW'(t)];
            cmd[l].b = estimate[SW'(t)];
          end
          ST_LY: begin
            cmd[l].a = l_store[SW'(ri)][OW'(t)];
            cmd[l].b = (32'(t) < 2) ? yv[t[0]] : '0;
          end
          ST_BU: begin
            cmd[l].a = b_store[SW'(ri)][OW'(t)];
            cmd[l].b = u[OW'(t)];
          end
          default: ;
        endcase
      end
    end
  end

  // result word, unused drives read as zero
  always_comb begin
    res_word = '0;
    for (int i = 0; i < 2; i++) begin
      if (i < 32'(no) && i < NO) begin
        res_word[32*i +: 32]    = u[i];
        res_word[64+32*i +: 32] = uraw[i];
        res_word[128+i]         = lim[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      m_tvalid <= 1'b0;
      num_states <= 3'd4;
      num_outputs <= 2'd2;
      for (int i = 0; i < NS; i++) estimate[i] <= '0;
      ti <= '0; ri <= '0; ci <= '0; drain <= '0; ph <= ST_IDLE;
    end else begin
      if (cfg_we) begin
        if (cfg_index == 1'b0) num_states <= cfg_data;
        else num_outputs <= cfg_data[1:0];
      end
      // output register is free when empty or taken this cycle
      if (state == ST_DONE && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (s_tvalid && s_tready) begin
            if (!mode) begin
              case (tab)
                TAB_A:  if (32'(lrow) < NS && 32'(lcol) < NS)
                          a_store[SW'(lrow)][SW'(lcol)] <= cval;
                TAB_B:  if (32'(lrow) < NS && 32'(lcol) < NO)
                          b_store[SW'(lrow)][OW'(lcol)] <= cval;
                TAB_C:  if (32'(lrow) < NO && 32'(lcol) < NS)
                          c_store[OW'(lrow)][SW'(lcol)] <= cval;
                TAB_K:  if (32'(lrow) < NO && 32'(lcol) < NS)
                          k_store[OW'(lrow)][SW'(lcol)] <= cval;
                TAB_L:  if (32'(lrow) < NS && 32'(lcol) < NO)
                          l_store[SW'(lrow)][OW'(lcol)] <= cval;
                TAB_LO: if (32'(lrow) < NO) low_limits[OW'(lrow)] <= cval;
                TAB_HI: if (32'(lrow) < NO) high_limits[OW'(lrow)] <= cval;
                default: ;
              endcase
            end else begin
              for (int i = 0; i < 4; i++) rv[i] <= s_tdata[36+32*i +: 32];
              yv[0] <= s_tdata[164 +: 32];
              yv[1] <= s_tdata[196 +: 32];
              state <= ST_R1;
            end
          end
        end
        ST_R1: begin
          for (int i = 0; i < NS; i++)
            r1[i] <= (i < 4) ? sadd(rv[i], estimate[i], 1'b1) : sadd('0, estimate[i], 1'b1);
          ri <= '0; ci <= '0; ti <= '0;
          state <= ST_U;
        end
        ST_U, ST_LC, ST_AX, ST_LY, ST_BU: begin
          if (ti + (IW+1)'(LANES) >= tlen) begin
            ph <= state;
            drain <= 3'd0;
            state <= ST_WAIT;
          end else ti <= ti + (IW+1)'(LANES);
        end
        ST_WAIT: begin
          // product reg, accumulator, merge reg
          if (drain == 3'd2) state <= ST_STORE;
          drain <= drain + 3'd1;
        end
        ST_STORE: begin
          ti <= '0;
          state <= ph;
          case (ph)
            ST_U: begin
              uraw[OW'(ri)] <= mres;
              lim[OW'(ri)] <= 1'b1;
              if (signed'(mres) < signed'(low_limits[OW'(ri)]))
                u[OW'(ri)] <= low_limits[OW'(ri)];
              else if (signed'(mres) > signed'(high_limits[OW'(ri)]))
                u[OW'(ri)] <= high_limits[OW'(ri)];
              else begin
                u[OW'(ri)] <= mres;
                lim[OW'(ri)] <= 1'b0;
              end
              if ((IW+1)'(ri) + 1'b1 >= no) begin
                ri <= '0; state <= ST_LC;
              end else ri <= ri + 1'b1;
            end
            ST_LC: begin
              alc[SW'(ri)][SW'(ci)] <= sadd(a_store[SW'(ri)][SW'(ci)], mres, 1'b1);
              if ((IW+1)'(ci) + 1'b1 >= ns) begin
                ci <= '0;
                if ((IW+1)'(ri) + 1'b1 >= ns) begin
                  ri <= '0; state <= ST_AX;
                end else ri <= ri + 1'b1;
              end else ci <= ci + 1'b1;
            end
            ST_AX: begin
              sx <= mres; state <= ST_LY;
            end
            ST_LY: begin
              sy <= sadd(sx, mres, 1'b0); state <= ST_BU;
            end
            ST_BU: begin
              nx[SW'(ri)] <= sadd(sy, mres, 1'b0);
              if ((IW+1)'(ri) + 1'b1 >= ns) state <= ST_DONE;
              else begin
                ri <= ri + 1'b1; state <= ST_AX;
              end
            end
            default: state <= ST_IDLE;
          endcase
        end
        ST_DONE: begin
          // hold until the previous result has left the output register
          if (!m_tvalid || m_tready) begin
            for (int i = 0; i < NS; i++) if (i < 32'(ns)) estimate[i] <= nx[i];
            m_tdata <= res_word;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // a result only appears straight after the write-back state
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_DONE) else $error("stray result");
  // no item taken while a step runs
  assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !s_tready) else $error("ready during step");
  // pipeline drain is bounded
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_WAIT) |-> drain < 3'd3) else $error("drain overrun");
endmodule
`default_nettype wire

### rtl/ssoc_lane.sv
// ssoc_lane: one multiply-accumulate lane, registered product, wide sum
// depends on ssoc_pkg
`timescale 1ns / 1ps
`default_nettype none
module ssoc_lane
  import ssoc_pkg::*;
(
  input  wire logic            clk,
  input  wire lane_cmd_t       cmd,
  output logic signed [PW+7:0] acc
);
  logic signed [PW-1:0] prod;
  logic                 prod_en;
  logic                 prod_clr;

  always_ff @(posedge clk) begin
    prod     <= 64'(signed'(cmd.a)) * 64'(signed'(cmd.b));
    prod_en  <= cmd.en;
    prod_clr <= cmd.clr;
    if (prod_clr) acc <= '0;
    else if (prod_en) acc <= acc + 72'(prod);
  end
endmodule
`default_nettype wire

### rtl/ssoc_merge.sv
// ssoc_merge: combines lane sums and scales Q32.32 back to saturated Q16.16
// depends on ssoc_pkg
`timescale 1ns / 1ps
`default_nettype none
module ssoc_merge
  import ssoc_pkg::*;
#(
  parameter int LANES = 2
) (
  input  wire logic                         clk,
  input  wire logic signed [LANES*(PW+8)-1:0] sums,
  output logic [QW-1:0]                     result
);
  logic signed [PW+7:0] tot;
  always_comb begin
    tot = '0;
    for (int i = 0; i < LANES; i++) tot = tot + sums[i*(PW+8) +: (PW+8)];
  end
  // floor shift of exact sum equals the per-term split form
  always_ff @(posedge clk) result <= sat32(tot >>> 16);
endmodule
`default_nettype wire
